// ===== hw/rtl/pab_pkg.sv =====
// Shared types and constants for the polygon area / bounding box block.
// No dependencies; imported by pab_ofifo and polygon_area_bbox.
package pab_pkg;

    localparam int COORD_BITS   = 24;
    localparam int MAX_VERTICES = 65536;
    localparam int AREA_BITS    = 49;
    localparam int CNT_BITS     = 17;
    localparam int SUM_BITS     = 64;
    localparam int PROD_BITS    = 2 * COORD_BITS;
    localparam int DIFF_BITS    = PROD_BITS + 1;
    localparam int SPAN_BITS    = COORD_BITS + 1;
    localparam int RECT_BITS    = 2 * SPAN_BITS + 1;

    // result buffer
    localparam int RES_DEPTH    = 2;
    localparam int RES_PTR_BITS = $clog2(RES_DEPTH);
    localparam int RES_CNT_BITS = $clog2(RES_DEPTH + 1);

    typedef logic signed [COORD_BITS-1:0] coord_t;

    typedef struct packed {
        coord_t vx;
        coord_t vy;
        logic   final_vertex;
    } pab_in_t;

    typedef struct packed {
        logic [AREA_BITS-1:0] area_x2;
        coord_t               box_xmin;
        coord_t               box_xmax;
        coord_t               box_ymin;
        coord_t               box_ymax;
        logic [CNT_BITS-1:0]  vertex_total;
    } pab_out_t;

    typedef struct packed {
        coord_t              xmin;
        coord_t              xmax;
        coord_t              ymin;
        coord_t              ymax;
        logic [CNT_BITS-1:0] count;
    } pab_box_t;

endpackage

// ===== hw/rtl/pab_ofifo.sv =====
// Small result buffer between the area pipeline and the result channel.
// Depends on pab_pkg (result word type, depth constants).
module pab_ofifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  pab_pkg::pab_out_t push_word,
    output logic              full,
    output logic              res_valid,
    input  logic              res_ready,
    output pab_pkg::pab_out_t res
);
    import pab_pkg::*;

    pab_out_t                mem_reg [RES_DEPTH];
    logic [RES_PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [RES_PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [RES_CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                    do_push, do_pop;

    assign full      = (cnt_reg == RES_CNT_BITS'(RES_DEPTH));
    assign res_valid = (cnt_reg != '0);
    assign res       = mem_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = res_valid && res_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == RES_PTR_BITS'(RES_DEPTH - 1)) ? '0
                                                                       : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == RES_PTR_BITS'(RES_DEPTH - 1)) ? '0
                                                                       : rd_ptr_reg + 1'b1;
        end
        unique case ({do_push, do_pop})
            2'b10:   cnt_next = cnt_reg + 1'b1;
            2'b01:   cnt_next = cnt_reg - 1'b1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_word;
        end
    end

endmodule

// ===== hw/rtl/polygon_area_bbox.sv =====
// Polygon area (shoelace) and bounding box accumulator, top level.
// Depends on pab_pkg and pab_ofifo.
//
//  channel | direction | handshake            | word
//  --------+-----------+----------------------+-------------------------------
//  vtx     | in        | vtx_valid/vtx_ready  | pab_in_t: vx, vy, final_vertex
//  res     | out       | res_valid/res_ready  | pab_out_t: area_x2, box, count
//  cfg     | in        | cfg_valid/cfg_ready  | cfg_data = rect_mode
//
// Rate: one vertex word per cycle while the pipeline is not held (see Stalls). A final
//   vertex's result reaches res through the input reg, products, differences,
//   sum/rect product and accumulate stages, then a buffer write.
// Stalls: a two-word result buffer sits at the output; the pipeline (and
//   vtx_ready) only holds when that buffer is full and the last stage carries
//   a result. vtx_ready depends on registers only.
// Reset: asynchronous, no clearing pass; cfg is always ready.
module polygon_area_bbox (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             vtx_valid,
    output logic             vtx_ready,
    input  pab_pkg::pab_in_t vtx,
    output logic             res_valid,
    input  logic             res_ready,
    output pab_pkg::pab_out_t res,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic             cfg_data
);
    import pab_pkg::*;

    localparam logic [CNT_BITS-1:0] CNT_MAX = CNT_BITS'(MAX_VERTICES);

    // config
    logic rect_mode_reg;

    // pipeline advance
    logic en;
    logic fifo_full;
    logic res_push;
    pab_out_t res_word;

    // polygon state (updated in stage 2)
    logic     in_poly_reg;
    coord_t   first_x_reg, first_y_reg, prev_x_reg, prev_y_reg;
    pab_box_t box_reg;
    pab_box_t box_next;
    coord_t   first_x_use, first_y_use;

    // running shoelace sum (updated at stage 4 -> 5)
    logic [SUM_BITS-1:0] cross_sum_reg;

    // stage 1: input register
    logic   s1_valid_reg, s1_fin_reg;
    coord_t s1_x_reg, s1_y_reg;

    // stage 2: products
    logic                        s2_valid_reg, s2_fin_reg, s2_first_reg;
    logic signed [PROD_BITS-1:0] s2_p1_reg, s2_p2_reg, s2_c1_reg, s2_c2_reg;
    pab_box_t                    s2_box_reg;

    // stage 3: cross terms and box spans
    logic                        s3_valid_reg, s3_fin_reg, s3_first_reg;
    logic [SUM_BITS-1:0]         s3_d_reg, s3_e_reg;
    logic [SPAN_BITS-1:0]        s3_w_reg, s3_h_reg;
    pab_box_t                    s3_box_reg;
    logic signed [DIFF_BITS-1:0] d_full, e_full;
    logic [SUM_BITS-1:0]         d_ext, e_ext;

    // stage 4: edge term, closing sum, rectangle product
    logic                        s4_valid_reg, s4_fin_reg, s4_first_reg;
    logic [SUM_BITS-1:0]         s4_d_reg, s4_de_reg;
    logic [2*SPAN_BITS-1:0]      s4_wh_reg;
    pab_box_t                    s4_box_reg;

    // stage 5: polygon total
    logic                        s5_valid_reg, s5_fin_reg;
    logic [SUM_BITS-1:0]         s5_total_reg;
    logic [2*SPAN_BITS-1:0]      s5_wh_reg;
    pab_box_t                    s5_box_reg;

    // result formatting
    logic [SUM_BITS-1:0]  abs_total;
    logic [RECT_BITS-1:0] rect_area;
    logic [SUM_BITS-1:0]  area_sel;

    assign cfg_ready = 1'b1;
    assign en        = !(s5_valid_reg && s5_fin_reg) || !fifo_full;
    assign vtx_ready = en;
    assign res_push  = en && s5_valid_reg && s5_fin_reg;

    // first vertex of a polygon is its own anchor
    assign first_x_use = in_poly_reg ? first_x_reg : s1_x_reg;
    assign first_y_use = in_poly_reg ? first_y_reg : s1_y_reg;

    always_comb
    begin
        box_next = box_reg;
        if (!in_poly_reg)
        begin
            box_next.xmin  = s1_x_reg;
            box_next.xmax  = s1_x_reg;
            box_next.ymin  = s1_y_reg;
            box_next.ymax  = s1_y_reg;
            box_next.count = CNT_BITS'(1);
        end
        else
        begin
            if (s1_x_reg < box_reg.xmin)
                box_next.xmin = s1_x_reg;
            if (s1_x_reg > box_reg.xmax)
                box_next.xmax = s1_x_reg;
            if (s1_y_reg < box_reg.ymin)
                box_next.ymin = s1_y_reg;
            if (s1_y_reg > box_reg.ymax)
                box_next.ymax = s1_y_reg;
            if (box_reg.count < CNT_MAX)
                box_next.count = box_reg.count + 1'b1;
        end
    end

    // edge term prev x cur, closing term cur x first
    always_comb
    begin
        d_full = DIFF_BITS'(s2_p1_reg) - DIFF_BITS'(s2_p2_reg);
        e_full = DIFF_BITS'(s2_c1_reg) - DIFF_BITS'(s2_c2_reg);
        d_ext  = SUM_BITS'(d_full);
        e_ext  = SUM_BITS'(e_full);
    end

    // magnitude, mode select, saturate
    always_comb
    begin
        abs_total = s5_total_reg[SUM_BITS-1] ? ('0 - s5_total_reg) : s5_total_reg;
        rect_area = {s5_wh_reg, 1'b0};
        area_sel  = rect_mode_reg ? SUM_BITS'(rect_area) : abs_total;
        res_word.area_x2 = (area_sel > SUM_BITS'({AREA_BITS{1'b1}}))
                           ? {AREA_BITS{1'b1}} : area_sel[AREA_BITS-1:0];
        res_word.box_xmin     = s5_box_reg.xmin;
        res_word.box_xmax     = s5_box_reg.xmax;
        res_word.box_ymin     = s5_box_reg.ymin;
        res_word.box_ymax     = s5_box_reg.ymax;
        res_word.vertex_total = s5_box_reg.count;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rect_mode_reg <= 1'b0;
            in_poly_reg   <= 1'b0;
            cross_sum_reg <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            s5_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                rect_mode_reg <= cfg_data;
            if (en)
            begin
                s1_valid_reg <= vtx_valid;
                s2_valid_reg <= s1_valid_reg;
                s3_valid_reg <= s2_valid_reg;
                s4_valid_reg <= s3_valid_reg;
                s5_valid_reg <= s4_valid_reg;
                if (s1_valid_reg)
                    in_poly_reg <= !s1_fin_reg;
                if (s4_valid_reg)
                    cross_sum_reg <= s4_fin_reg ? '0 : cross_sum_reg + s4_d_reg;
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // stage 1
            s1_x_reg   <= vtx.vx;
            s1_y_reg   <= vtx.vy;
            s1_fin_reg <= vtx.final_vertex;

            // stage 2 and polygon state
            if (s1_valid_reg)
            begin
                prev_x_reg  <= s1_x_reg;
                prev_y_reg  <= s1_y_reg;
                first_x_reg <= first_x_use;
                first_y_reg <= first_y_use;
                box_reg     <= box_next;
            end
            s2_fin_reg   <= s1_fin_reg;
            s2_first_reg <= !in_poly_reg;
            s2_p1_reg    <= PROD_BITS'(prev_x_reg) * PROD_BITS'(s1_y_reg);
            s2_p2_reg    <= PROD_BITS'(s1_x_reg) * PROD_BITS'(prev_y_reg);
            s2_c1_reg    <= PROD_BITS'(s1_x_reg) * PROD_BITS'(first_y_use);
            s2_c2_reg    <= PROD_BITS'(first_x_use) * PROD_BITS'(s1_y_reg);
            s2_box_reg   <= box_next;

            // stage 3: no edge term on a first vertex, closing only on final
            s3_fin_reg   <= s2_fin_reg;
            s3_first_reg <= s2_first_reg;
            s3_d_reg     <= s2_first_reg ? '0 : d_ext;
            s3_e_reg     <= s2_fin_reg ? e_ext : '0;
            s3_w_reg     <= SPAN_BITS'(s2_box_reg.xmax) - SPAN_BITS'(s2_box_reg.xmin);
            s3_h_reg     <= SPAN_BITS'(s2_box_reg.ymax) - SPAN_BITS'(s2_box_reg.ymin);
            s3_box_reg   <= s2_box_reg;

            // stage 4
            s4_fin_reg   <= s3_fin_reg;
            s4_first_reg <= s3_first_reg;
            s4_d_reg     <= s3_d_reg;
            s4_de_reg    <= s3_d_reg + s3_e_reg;
            s4_wh_reg    <= (2*SPAN_BITS)'(s3_w_reg) * (2*SPAN_BITS)'(s3_h_reg);
            s4_box_reg   <= s3_box_reg;

            // stage 5
            s5_fin_reg   <= s4_fin_reg;
            s5_total_reg <= cross_sum_reg + s4_de_reg;
            s5_wh_reg    <= s4_wh_reg;
            s5_box_reg   <= s4_box_reg;
        end
    end

    pab_ofifo u_ofifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_push),
        .push_word (res_word),
        .full      (fifo_full),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

`ifndef SYNTH
    // a result never reaches a full buffer
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !fifo_full)
        else $error("result pushed into full buffer");

    // a final vertex closes the polygon
    a_close_poly: assert property (@(posedge clk) disable iff (!rst_n)
        (en && s1_valid_reg && s1_fin_reg) |=> !in_poly_reg)
        else $error("polygon still open after final vertex");

    // the sum is clear when a polygon's first vertex reaches the accumulator
    a_sum_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (s4_valid_reg && s4_first_reg) |-> (cross_sum_reg == '0))
        else $error("cross sum not cleared at polygon start");
`endif

endmodule

// ===== sim/tb_polygon_area_bbox.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for polygon_area_bbox: shoelace / box area, bounding box, vertex count.
// Depends on pab_pkg and the polygon_area_bbox RTL; needs no files or arguments.
module tb_polygon_area_bbox;
    import pab_pkg::*;

    // rect_mode register values
    localparam bit MODE_SHOELACE = 1'b0;
    localparam bit MODE_RECT     = 1'b1;

    localparam coord_t C_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
    localparam coord_t C_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};

    localparam logic [63:0] AREA_SAT = (64'd1 << AREA_BITS) - 64'd1;
    // 2 * (2^24 - 1)^2: full-range box in rectangle mode, just under saturation
    localparam logic [AREA_BITS-1:0] RECT_FULL = 49'h1_FFFF_FC00_0002;

    // pipeline is five deep; leave margin before touching the register
    localparam int DRAIN_CYCLES  = 12;
    localparam int RAND_PHASES   = 8;
    localparam int PHASE_WORDS   = 250;

    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     vtx_valid = 1'b0;
    logic     vtx_ready;
    pab_in_t  vtx       = '0;
    logic     res_valid;
    logic     res_ready = 1'b0;
    pab_out_t res;
    logic     cfg_valid = 1'b0;
    logic     cfg_ready;
    logic     cfg_data  = 1'b0;

    polygon_area_bbox dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .vtx_valid (vtx_valid),
        .vtx_ready (vtx_ready),
        .vtx       (vtx),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor state: our own copy of the accumulator and the register.
    // Coordinates are held sign-extended to 64 bits; the cross sum wraps
    // at 64 bits like the hardware accumulator.
    // ------------------------------------------------------------------
    bit          rect_mode_q;
    bit          poly_open;
    longint      fx, fy, px, py;
    longint      xlo, xhi, ylo, yhi;
    bit   [63:0] csum;
    int          nseen;

    // expected result words, oldest first
    pab_out_t results_due [$];

    int mismatch_cnt    = 0;
    int results_checked = 0;
    int vertices_sent   = 0;
    int burst_left      = 0;
    int stall_mode      = 0;
    int stall_left      = 0;

    // Advance the model by one accepted vertex word. hit is set when the
    // word closes a polygon; r then holds the result the block must emit.
    task automatic shoelace_step(input pab_in_t w, output bit hit, output pab_out_t r);
        longint      x, y;
        logic [63:0] mag;
        x = longint'(w.vx);
        y = longint'(w.vy);
        if (!poly_open)
        begin
            // first vertex opens a fresh polygon
            fx = x;  fy = y;
            csum = '0;
            xlo = x; xhi = x;
            ylo = y; yhi = y;
            nseen = 1;
            poly_open = 1'b1;
        end
        else
        begin
            csum = csum + (px * y - x * py);
            if (x < xlo) xlo = x;
            if (x > xhi) xhi = x;
            if (y < ylo) ylo = y;
            if (y > yhi) yhi = y;
            // count saturates; area and box keep going
            if (nseen < MAX_VERTICES) nseen++;
        end
        px = x;
        py = y;
        hit = w.final_vertex;
        r = '0;
        if (hit)
        begin
            // closing edge back to the first vertex
            csum = csum + (px * fy - fx * py);
            if (rect_mode_q == MODE_RECT)
                mag = 64'(2 * ((xhi - xlo) * (yhi - ylo)));
            else
                mag = csum[63] ? (64'd0 - csum) : csum;   // clockwise gives a negative sum
            if (mag > AREA_SAT) mag = AREA_SAT;
            r.area_x2      = mag[AREA_BITS-1:0];
            r.box_xmin     = xlo[COORD_BITS-1:0];
            r.box_xmax     = xhi[COORD_BITS-1:0];
            r.box_ymin     = ylo[COORD_BITS-1:0];
            r.box_ymax     = yhi[COORD_BITS-1:0];
            r.vertex_total = nseen[CNT_BITS-1:0];
            poly_open = 1'b0;
        end
    endtask

    // ------------------------------------------------------------------
    // Vertex sender. Works in bursts of random length; between bursts it
    // drops valid for a random gap. Valid is only lowered at the start of
    // a gap, never in the step where the next word goes out.
    // ------------------------------------------------------------------
    task automatic drive_vertex(input pab_in_t w);
        int gap;
        if (burst_left == 0)
        begin
            // mostly short bursts, now and then a long unbroken stretch
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 24);
            gap = $urandom_range(0, 10);
            if (gap != 0)
            begin
                vtx_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        vtx_valid <= 1'b1;
        vtx       <= w;
        do @(posedge clk); while (!vtx_ready);
        burst_left--;
    endtask

    // Send one word and queue what it should produce. A typed expectation
    // replaces the predicted one for rows whose result is known by hand.
    task automatic feed_vertex(input pab_in_t w, input bit typed, input pab_out_t typed_res);
        bit       hit;
        pab_out_t r;
        drive_vertex(w);
        shoelace_step(w, hit, r);
        vertices_sent++;
        if (hit) results_due.push_back(typed ? typed_res : r);
    endtask

    // Register write, only with the block drained: every expected word has
    // come back, then a further DRAIN_CYCLES wait for trailing non-final vertices.
    task automatic set_rect_mode(input bit m);
        vtx_valid <= 1'b0;
        while (results_due.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= m;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid   <= 1'b0;
        rect_mode_q  = m;
        burst_left   = 0;
    endtask

    // ------------------------------------------------------------------
    // Result side: check each accepted word, then pick the next ready.
    // Stall pattern: windows of always-ready, coin-flip, mostly stalled
    // and fully stalled, each of random length.
    // ------------------------------------------------------------------
    task automatic cmp_field(input string name, input longint want, input longint got);
        if (want != got)
        begin
            mismatch_cnt++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    task automatic check_result(input pab_out_t got);
        pab_out_t want;
        if (results_due.size() == 0)
        begin
            mismatch_cnt++;
            $display("%0t: unexpected result word, expected none, actual %p", $time, got);
        end
        else
        begin
            want = results_due.pop_front();
            cmp_field("area_x2", longint'(want.area_x2), longint'(got.area_x2));
            cmp_field("box_xmin", longint'(want.box_xmin), longint'(got.box_xmin));
            cmp_field("box_xmax", longint'(want.box_xmax), longint'(got.box_xmax));
            cmp_field("box_ymin", longint'(want.box_ymin), longint'(got.box_ymin));
            cmp_field("box_ymax", longint'(want.box_ymax), longint'(got.box_ymax));
            cmp_field("vertex_total", longint'(want.vertex_total),
                      longint'(got.vertex_total));
            results_checked++;
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
            res_ready <= 1'b0;
        else
        begin
            if (res_valid && res_ready) check_result(res);
            if (stall_left == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                stall_left = $urandom_range(1, 48);
            end
            stall_left--;
            case (stall_mode)
                0:       res_ready <= 1'b1;
                1:       res_ready <= 1'($urandom_range(0, 1));
                2:       res_ready <= ($urandom_range(0, 3) == 0);
                default: res_ready <= 1'b0;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Directed table: one row is either a register write or a vertex.
    // ------------------------------------------------------------------
    typedef struct {
        bit       is_cfg;
        bit       mode;
        pab_in_t  w;
        bit       typed;
        pab_out_t res;
    } stim_row_t;

    function automatic stim_row_t vrow(input coord_t x, input coord_t y, input bit f);
        stim_row_t s;
        s = '{is_cfg: 1'b0, mode: 1'b0, w: '0, typed: 1'b0, res: '0};
        s.w.vx = x;
        s.w.vy = y;
        s.w.final_vertex = f;
        return s;
    endfunction

    // closing vertex with its result written out by hand
    function automatic stim_row_t trow(input coord_t x, input coord_t y,
                                       input logic [AREA_BITS-1:0] a,
                                       input coord_t xmn, input coord_t xmx,
                                       input coord_t ymn, input coord_t ymx,
                                       input int cnt);
        stim_row_t s;
        s = vrow(x, y, 1'b1);
        s.typed = 1'b1;
        s.res = '{area_x2: a, box_xmin: xmn, box_xmax: xmx, box_ymin: ymn,
                  box_ymax: ymx, vertex_total: cnt[CNT_BITS-1:0]};
        return s;
    endfunction

    function automatic stim_row_t crow(input bit m);
        stim_row_t s;
        s = vrow('0, '0, 1'b0);
        s.is_cfg = 1'b1;
        s.mode = m;
        return s;
    endfunction

    // random coordinate: full range, small around zero, or corner values
    function automatic coord_t pick_coord(input int style);
        case (style)
            0: return coord_t'($urandom);
            1: return coord_t'(int'($urandom_range(0, 400)) - 200);
            default:
                case ($urandom_range(0, 4))
                    0:       return C_MIN;
                    1:       return C_MAX;
                    2:       return coord_t'(0);
                    3:       return coord_t'(-1);
                    default: return coord_t'($urandom);
                endcase
        endcase
    endfunction

    stim_row_t dir_tab [$];

    initial
    begin
        pab_in_t w;
        int      budget, len, style, ph, k;
        bit      leave_open;

        // model state matches the block after reset
        rect_mode_q = MODE_SHOELACE;
        poly_open   = 1'b0;
        csum = '0;
        fx = 0; fy = 0; px = 0; py = 0;
        xlo = 0; xhi = 0; ylo = 0; yhi = 0;
        nseen = 0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // lone point: zero area, box collapses to the point
        dir_tab.push_back(trow(5, -7, '0, 5, 5, -7, -7, 1));
        // two opposite corners: cross terms cancel
        dir_tab.push_back(vrow(C_MIN, C_MIN, 1'b0));
        dir_tab.push_back(trow(C_MAX, C_MAX, '0, C_MIN, C_MAX, C_MIN, C_MAX, 2));
        // square counterclockwise, then clockwise: same magnitude
        dir_tab.push_back(vrow(0, 0, 1'b0));
        dir_tab.push_back(vrow(10, 0, 1'b0));
        dir_tab.push_back(vrow(10, 10, 1'b0));
        dir_tab.push_back(trow(0, 10, 200, 0, 10, 0, 10, 4));
        dir_tab.push_back(vrow(0, 0, 1'b0));
        dir_tab.push_back(vrow(0, 10, 1'b0));
        dir_tab.push_back(vrow(10, 10, 1'b0));
        dir_tab.push_back(trow(10, 0, 200, 0, 10, 0, 10, 4));
        // full-range triangle wound three times: area saturates
        for (k = 0; k < 3; k++)
        begin
            dir_tab.push_back(vrow(C_MIN, C_MIN, 1'b0));
            dir_tab.push_back(vrow(C_MAX, C_MIN, 1'b0));
            if (k < 2)
                dir_tab.push_back(vrow(C_MIN, C_MAX, 1'b0));
            else
                dir_tab.push_back(trow(C_MIN, C_MAX, AREA_SAT[AREA_BITS-1:0],
                                       C_MIN, C_MAX, C_MIN, C_MAX, 9));
        end
        // rectangle mode over the widest possible box
        dir_tab.push_back(crow(MODE_RECT));
        dir_tab.push_back(vrow(C_MIN, C_MIN, 1'b0));
        dir_tab.push_back(trow(C_MAX, C_MAX, RECT_FULL, C_MIN, C_MAX, C_MIN, C_MAX, 2));
        // mode flipped back mid polygon: shoelace result (18, not 36)
        dir_tab.push_back(vrow(0, 0, 1'b0));
        dir_tab.push_back(vrow(6, 0, 1'b0));
        dir_tab.push_back(crow(MODE_SHOELACE));
        dir_tab.push_back(trow(0, 3, 18, 0, 6, 0, 3, 3));

        foreach (dir_tab[i])
        begin
            if (dir_tab[i].is_cfg)
                set_rect_mode(dir_tab[i].mode);
            else
                feed_vertex(dir_tab[i].w, dir_tab[i].typed, dir_tab[i].res);
        end

        // Random phases. Polygons are mostly short, some a few dozen long;
        // a phase may stop with its last polygon still open, so the next
        // register write lands mid polygon.
        for (ph = 0; ph < RAND_PHASES; ph++)
        begin
            if (ph == 0)
                set_rect_mode(MODE_RECT);
            else if (ph == 1)
                set_rect_mode(MODE_SHOELACE);
            else
                set_rect_mode(1'($urandom_range(0, 1)));
            budget = PHASE_WORDS;
            while (budget > 0)
            begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 60)
                                                  : $urandom_range(1, 8);
                style = $urandom_range(0, 2);
                leave_open = (budget <= len) && ($urandom_range(0, 2) == 0);
                for (k = 0; k < len; k++)
                begin
                    w.vx = pick_coord(style);
                    w.vy = pick_coord(style);
                    w.final_vertex = (k == len - 1) && !leave_open;
                    feed_vertex(w, 1'b0, '0);
                end
                budget -= len;
            end
        end

        vtx_valid <= 1'b0;
        while (results_due.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d vertex words, checked %0d polygon results", vertices_sent,
                 results_checked);
        $display("Both area modes, saturated area, mid-polygon mode switches");
        if (mismatch_cnt == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // watchdog: several times the slowest legal run
    initial
    begin
        #12_000_000;
        $display("Timeout with %0d result words outstanding", results_due.size());
        $display("Regression FAIL");
        $finish;
    end

endmodule
